FILE: rtl/dce_pkg.sv
//------------------------------------------------------------------------------
// dce_pkg
// Shared types and codes for the distinct common elements block.
//------------------------------------------------------------------------------
package dce_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int DATA_W        = 32;
    localparam int REQ_W         = 2;
    localparam int MATCH_W       = 6;

    localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RUN    = 2'd2;

    localparam logic KIND_VALUE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_X,
        S_LD_X,
        S_RD_B,
        S_CMP_B,
        S_RD_A,
        S_CMP_A,
        S_EMIT,
        S_NEXT,
        S_SUM
    } t_state;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic start;
        logic rd_x;
        logic latch_x;
        logic rd_b;
        logic clr_k;
        logic rd_a;
        logic inc_i;
        logic emit_val;
        logic emit_sum;
    } t_cmd;

    typedef struct packed {
        logic i_end;
        logic j_end;
        logic k_end;
        logic b_match;
        logic a_match;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/dce_ctrl.sv
//------------------------------------------------------------------------------
// dce_ctrl
// Sequencer: takes requests when idle and walks both stores during a run.
//------------------------------------------------------------------------------
module dce_ctrl
    import dce_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [REQ_W-1:0] i_req_type,
    input  t_status          i_status,
    output t_cmd             o_cmd,
    output logic             o_stall
);

    t_state r_state;
    t_state n_state;
    logic   w_take;

    assign w_take = i_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_take && i_req_type == REQ_RUN) n_state = S_RD_X;
            end
            S_RD_X: begin
                n_state = i_status.i_end ? S_SUM : S_LD_X;
            end
            S_LD_X: begin
                n_state = S_RD_B;
            end
            S_RD_B: begin
                n_state = i_status.j_end ? S_NEXT : S_CMP_B;
            end
            S_CMP_B: begin
                n_state = i_status.b_match ? S_RD_A : S_RD_B;
            end
            S_RD_A: begin
                n_state = i_status.k_end ? S_EMIT : S_CMP_A;
            end
            S_CMP_A: begin
                n_state = i_status.a_match ? S_NEXT : S_RD_A;
            end
            S_EMIT: begin
                if (i_status.out_free) n_state = S_NEXT;
            end
            S_NEXT: begin
                n_state = S_RD_X;
            end
            S_SUM: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.load_a = w_take && i_req_type == REQ_LOAD_A;
                o_cmd.load_b = w_take && i_req_type == REQ_LOAD_B;
                o_cmd.start  = w_take && i_req_type == REQ_RUN;
            end
            S_RD_X:  o_cmd.rd_x     = !i_status.i_end;
            S_LD_X:  o_cmd.latch_x  = 1'b1;
            S_RD_B:  o_cmd.rd_b     = !i_status.j_end;
            S_CMP_B: o_cmd.clr_k    = i_status.b_match;
            S_RD_A:  o_cmd.rd_a     = !i_status.k_end;
            S_CMP_A: o_cmd.rd_a     = 1'b0;
            S_EMIT:  o_cmd.emit_val = i_status.out_free;
            S_NEXT:  o_cmd.inc_i    = 1'b1;
            S_SUM:   o_cmd.emit_sum = i_status.out_free;
            default: o_cmd          = '0;
        endcase
    end

endmodule

FILE: rtl/dce_datapath.sv
//------------------------------------------------------------------------------
// dce_datapath
// Both list stores, lengths, scan counters, comparators and the output register.
//------------------------------------------------------------------------------
module dce_datapath
    import dce_pkg::*;
#(
    parameter int LIST_DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic signed [DATA_W-1:0] i_elem_value,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic                     i_stall,
    output logic                     o_valid,
    output logic                     o_item_kind,
    output logic signed [DATA_W-1:0] o_common_value,
    output logic [MATCH_W-1:0]       o_match_count,
    output logic                     o_overflowed,
    output logic                     o_last_of_run
);

    localparam int LW = $clog2(LIST_DEPTH + 1);
    localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [LW-1:0] FULL = LW'(LIST_DEPTH);

    logic [DATA_W-1:0] mem_a [LIST_DEPTH];
    logic [DATA_W-1:0] mem_b [LIST_DEPTH];

    logic [LW-1:0]      r_len_a;
    logic [LW-1:0]      r_len_b;
    logic               r_ovf;
    logic [LW-1:0]      r_i;
    logic [LW-1:0]      r_j;
    logic [LW-1:0]      r_k;
    logic [MATCH_W-1:0] r_count;
    logic [DATA_W-1:0]  r_x;
    logic [DATA_W-1:0]  r_a_rdata;
    logic [DATA_W-1:0]  r_b_rdata;
    logic [IW-1:0]      w_a_addr;

    assign w_a_addr = i_cmd.rd_x ? r_i[IW-1:0] : r_k[IW-1:0];

    // stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a && r_len_a != FULL) mem_a[r_len_a[IW-1:0]] <= i_elem_value;
        if (i_cmd.rd_x || i_cmd.rd_a) r_a_rdata <= mem_a[w_a_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_b && r_len_b != FULL) mem_b[r_len_b[IW-1:0]] <= i_elem_value;
        if (i_cmd.rd_b) r_b_rdata <= mem_b[r_j[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a <= '0;
            r_len_b <= '0;
            r_ovf   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.load_a) begin
                if (r_len_a != FULL) r_len_a <= r_len_a + 1'b1;
                else                 r_ovf   <= 1'b1;
            end
            if (i_cmd.load_b) begin
                if (r_len_b != FULL) r_len_b <= r_len_b + 1'b1;
                else                 r_ovf   <= 1'b1;
            end
            if (i_cmd.start) begin
                r_i     <= '0;
                r_count <= '0;
            end
            if (i_cmd.inc_i)    r_i     <= r_i + 1'b1;
            if (i_cmd.latch_x)  r_j     <= '0;
            if (i_cmd.rd_b)     r_j     <= r_j + 1'b1;
            if (i_cmd.clr_k)    r_k     <= '0;
            if (i_cmd.rd_a)     r_k     <= r_k + 1'b1;
            if (i_cmd.emit_val) r_count <= r_count + 1'b1;
            if (i_cmd.emit_sum) begin
                r_len_a <= '0;
                r_len_b <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_x) r_x <= r_a_rdata;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.emit_val || i_cmd.emit_sum) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_val) begin
            o_item_kind    <= KIND_VALUE;
            o_common_value <= r_x;
            o_match_count  <= '0;
            o_overflowed   <= 1'b0;
            o_last_of_run  <= 1'b0;
        end else if (i_cmd.emit_sum) begin
            o_item_kind    <= KIND_SUMMARY;
            o_common_value <= '0;
            o_match_count  <= r_count;
            o_overflowed   <= r_ovf;
            o_last_of_run  <= 1'b1;
        end
    end

    assign o_status.i_end    = (r_i == r_len_a);
    assign o_status.j_end    = (r_j == r_len_b);
    assign o_status.k_end    = (r_k == r_i);
    assign o_status.b_match  = (r_b_rdata == r_x);
    assign o_status.a_match  = (r_a_rdata == r_x);
    assign o_status.out_free = !o_valid || !i_stall;

endmodule

FILE: rtl/distinct_common_elements.sv
//------------------------------------------------------------------------------
// distinct_common_elements
// Distinct values of the first list that also occur in the second list.
//------------------------------------------------------------------------------
// Request channel (i_valid / o_stall): req_type 0 appends elem_value to the
// first list, 1 to the second list, 2 starts a run; code 3 is taken and
// ignored. Appends may follow back to back. An append to a full list is
// dropped and raises the overflow flag. A run holds o_stall high while it
// walks the stores through one read port per store. For each first-list
// element i it scans the second list and, on a match, the earlier first-list
// entries to skip repeats.
// Result channel (o_valid / i_stall): one value item per distinct common
// value in first-list order, then a summary item with the count and
// overflow flag and last_of_run set. The run then empties both lists.
// Results sit in an output register; a stalled receiver holds the item and
// pauses the walk, while appends are still taken once the run is done.
// Reset (synchronous, active low) empties both lists, clears the flag and
// drops any pending result; store contents are not cleared.
//------------------------------------------------------------------------------
module distinct_common_elements
    import dce_pkg::*;
#(
    parameter int LIST_DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [REQ_W-1:0]         i_req_type,
    input  logic signed [DATA_W-1:0] i_elem_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_item_kind,
    output logic signed [DATA_W-1:0] o_common_value,
    output logic [MATCH_W-1:0]       o_match_count,
    output logic                     o_overflowed,
    output logic                     o_last_of_run
);

    t_cmd    w_cmd;
    t_status w_status;

    dce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_stall    (o_stall)
    );

    dce_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_elem_value   (i_elem_value),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_item_kind    (o_item_kind),
        .o_common_value (o_common_value),
        .o_match_count  (o_match_count),
        .o_overflowed   (o_overflowed),
        .o_last_of_run  (o_last_of_run)
    );

    a_run_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_req_type == REQ_RUN) |=> o_stall)
        else $error("run request did not stall the request channel");

    a_value_item_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item_kind == KIND_VALUE) |->
            (!o_last_of_run && !o_overflowed && o_match_count == '0))
        else $error("value item carries summary fields");

    a_summary_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item_kind == KIND_SUMMARY) |->
            (o_last_of_run && o_common_value == '0
             && o_match_count <= MATCH_W'(LIST_DEPTH)))
        else $error("summary item malformed");

endmodule

FILE: tb/sv/distinct_common_elements_tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// distinct_common_elements_tb
// Self-checking bench for the distinct common elements block.
//------------------------------------------------------------------------------
// Requests load both lists and start runs. A queue-fed driver offers them, and
// an in-bench model of the intersection predicts every value and summary item
// from each accepted request. A monitor compares results in order. Runs cover
// empty lists, repeats, full-range values, a full match set with both lists
// overflowing, and ignored request codes. Idling and stalling change per
// phase, and one long receiver hold-off backs the block up into its input.
//------------------------------------------------------------------------------
module distinct_common_elements_tb
    import dce_pkg::*;
();

    localparam int DEPTH          = DEPTH_DEFAULT;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 100;
    localparam int WATCHDOG_LIMIT = 20000;

    localparam logic [REQ_W-1:0]         REQ_UNUSED = 2'd3;
    localparam logic signed [DATA_W-1:0] VAL_MIN    = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX    = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct {
        logic [REQ_W-1:0]         code;
        logic signed [DATA_W-1:0] value;
    } t_list_req;

    typedef struct {
        logic                     kind;
        logic signed [DATA_W-1:0] value;
        logic [MATCH_W-1:0]       count;
        logic                     ovf;
        logic                     last;
    } t_match_item;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_valid      = 1'b0;
    logic [REQ_W-1:0]         i_req_type   = '0;
    logic signed [DATA_W-1:0] i_elem_value = '0;
    logic                     i_stall      = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic                     o_item_kind;
    logic signed [DATA_W-1:0] o_common_value;
    logic [MATCH_W-1:0]       o_match_count;
    logic                     o_overflowed;
    logic                     o_last_of_run;

    t_list_req                pending_reqs[$];
    t_match_item              expected_matches[$];
    logic signed [DATA_W-1:0] first_store[$];
    logic signed [DATA_W-1:0] second_store[$];
    bit                       overflow_flag = 1'b0;

    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int hold_count     = 0;
    bit hold_trigger   = 1'b0;
    bit hold_done      = 1'b0;

    distinct_common_elements #(.LIST_DEPTH(DEPTH)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_elem_value   (i_elem_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_item_kind    (o_item_kind),
        .o_common_value (o_common_value),
        .o_match_count  (o_match_count),
        .o_overflowed   (o_overflowed),
        .o_last_of_run  (o_last_of_run)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic void push_req(input logic [REQ_W-1:0] code,
                                     input logic signed [DATA_W-1:0] value);
        t_list_req r;
        r.code  = code;
        r.value = value;
        pending_reqs.push_back(r);
    endfunction

    function automatic void predict_intersection(input logic [REQ_W-1:0] code,
                                                 input logic signed [DATA_W-1:0] value);
        t_match_item item;
        int          found;
        int          i;
        int          j;
        bit          hit;
        bit          repeated;
        found = 0;
        case (code)
            REQ_LOAD_A: begin
                if (first_store.size() < DEPTH) first_store.push_back(value);
                else overflow_flag = 1'b1;
            end
            REQ_LOAD_B: begin
                if (second_store.size() < DEPTH) second_store.push_back(value);
                else overflow_flag = 1'b1;
            end
            REQ_RUN: begin
                for (i = 0; i < first_store.size(); i++) begin
                    hit      = 1'b0;
                    repeated = 1'b0;
                    for (j = 0; j < i; j++)
                        if (first_store[j] == first_store[i]) repeated = 1'b1;
                    for (j = 0; j < second_store.size(); j++)
                        if (second_store[j] == first_store[i]) hit = 1'b1;
                    if (hit && !repeated) begin
                        item = '{kind: KIND_VALUE, value: first_store[i], count: '0,
                                 ovf: 1'b0, last: 1'b0};
                        expected_matches.push_back(item);
                        found++;
                    end
                end
                item = '{kind: KIND_SUMMARY, value: '0, count: found[MATCH_W-1:0],
                         ovf: overflow_flag, last: 1'b1};
                expected_matches.push_back(item);
                first_store.delete();
                second_store.delete();
                overflow_flag = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // Lists drawn from a small pool so that repeats and matches are common.
    function automatic int add_list_pair(input int len_a, input int len_b, input int pool_n);
        logic signed [DATA_W-1:0] vals [8];
        logic signed [DATA_W-1:0] pick;
        int                       k;
        int                       ia;
        int                       ib;
        int                       pushed;
        for (k = 0; k < pool_n; k++) vals[k] = $urandom;
        ia     = 0;
        ib     = 0;
        pushed = 1;
        while (ia < len_a || ib < len_b) begin
            if ($urandom_range(0, 9) == 0) push_req(REQ_UNUSED, $urandom);
            pick = ($urandom_range(0, 5) == 0) ? $urandom : vals[$urandom_range(0, pool_n - 1)];
            if (ib >= len_b || (ia < len_a && $urandom_range(0, 1) == 1)) begin
                push_req(REQ_LOAD_A, pick);
                ia++;
            end else begin
                push_req(REQ_LOAD_B, pick);
                ib++;
            end
            pushed++;
        end
        push_req(REQ_RUN, $urandom);
        return pushed;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || i_valid || expected_matches.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin : request_driver
        t_list_req next_req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_intersection(i_req_type, i_elem_value);
            end
            if (!i_valid || !o_stall) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_req = pending_reqs.pop_front();
                    i_valid      <= 1'b1;
                    i_req_type   <= next_req.code;
                    i_elem_value <= next_req.value;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_trigger && !hold_done) begin
            i_stall    <= 1'b1;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_match_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_matches.size() == 0) begin
                report_mismatch("result with nothing pending", o_common_value, 0);
            end else begin
                want = expected_matches.pop_front();
                if (o_item_kind !== want.kind)
                    report_mismatch("item_kind", o_item_kind, want.kind);
                if (o_common_value !== want.value)
                    report_mismatch("common_value", o_common_value, want.value);
                if (o_match_count !== want.count)
                    report_mismatch("match_count", o_match_count, want.count);
                if (o_overflowed !== want.ovf)
                    report_mismatch("overflowed", o_overflowed, want.ovf);
                if (o_last_of_run !== want.last)
                    report_mismatch("last_of_run", o_last_of_run, want.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("distinct_common_elements_tb: errors");
            $finish;
        end
    end

    initial begin : stimulus
        logic signed [DATA_W-1:0] pool [DEPTH];
        logic signed [DATA_W-1:0] shuffled [DEPTH];
        logic signed [DATA_W-1:0] tmp;
        int                       phase;
        int                       added;
        int                       ia;
        int                       ib;
        int                       k;
        int                       m;
        bit                       fresh;

        wait (i_rst_n === 1'b1);
        @(negedge i_clk);

        // empty lists, then one list empty at a time
        push_req(REQ_RUN, VAL_MAX);
        push_req(REQ_LOAD_A, VAL_MIN);
        push_req(REQ_RUN, '0);
        push_req(REQ_LOAD_B, 7);
        push_req(REQ_RUN, -1);
        // extremes and repeats on both sides
        push_req(REQ_LOAD_A, VAL_MIN);
        push_req(REQ_LOAD_A, VAL_MAX);
        push_req(REQ_LOAD_A, 0);
        push_req(REQ_LOAD_A, -1);
        push_req(REQ_LOAD_A, VAL_MIN);
        push_req(REQ_LOAD_A, VAL_MAX);
        push_req(REQ_LOAD_B, -1);
        push_req(REQ_LOAD_B, 0);
        push_req(REQ_LOAD_B, VAL_MAX);
        push_req(REQ_LOAD_B, VAL_MIN);
        push_req(REQ_LOAD_B, -1);
        push_req(REQ_UNUSED, 32'sh5A5A_A5A5);
        push_req(REQ_RUN, 32'sh1234_5678);
        // both lists loaded, nothing in common
        push_req(REQ_LOAD_A, 32'shAAAA_AAAA);
        push_req(REQ_LOAD_B, 32'sh5555_5555);
        push_req(REQ_RUN, 0);
        wait_drained();

        // full match set, one extra load per list dropped; receiver held off
        hold_trigger = 1'b1;
        for (k = 0; k < DEPTH; k++) begin
            do begin
                tmp   = $urandom;
                fresh = 1'b1;
                for (m = 0; m < k; m++)
                    if (pool[m] == tmp) fresh = 1'b0;
            end while (!fresh);
            pool[k]     = tmp;
            shuffled[k] = tmp;
        end
        for (k = DEPTH - 1; k > 0; k--) begin
            m           = $urandom_range(0, k);
            tmp         = shuffled[k];
            shuffled[k] = shuffled[m];
            shuffled[m] = tmp;
        end
        ia = 0;
        ib = 0;
        while (ia <= DEPTH || ib <= DEPTH) begin
            if (ib > DEPTH || (ia <= DEPTH && $urandom_range(0, 1) == 1)) begin
                push_req(REQ_LOAD_A, (ia < DEPTH) ? pool[ia] : $urandom);
                ia++;
            end else begin
                push_req(REQ_LOAD_B, (ib < DEPTH) ? shuffled[ib] : $urandom);
                ib++;
            end
        end
        push_req(REQ_RUN, $urandom);
        added = 0;
        while (added < 2)
            added += add_list_pair($urandom_range(0, 6), $urandom_range(0, 6),
                                   $urandom_range(1, 8));
        wait_drained();

        for (phase = 1; phase < 4; phase++) begin
            case (phase)
                1: begin
                    send_idle_pct = 73;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 73;
                end
                default: begin
                    send_idle_pct = 12;
                    stall_pct     = 12;
                end
            endcase
            added = 0;
            while (added < 4)
                added += add_list_pair($urandom_range(0, 6), $urandom_range(0, 6),
                                       $urandom_range(1, 8));
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("distinct_common_elements_tb: clean");
        end else begin
            $display("distinct_common_elements_tb: errors");
        end
        $finish;
    end

endmodule
